// File: rtl/hrhp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes, types and text tables of the request head parser.
package hrhp_pkg;

  localparam int unsigned MaxHeaderCount = 256;
  localparam int unsigned OffsetBits     = 20;
  localparam int unsigned LimitW         = 21;
  localparam int unsigned QueueDepth     = 2;
  localparam int unsigned NumMethods     = 9;
  localparam int unsigned LenW           = 31;

  localparam logic [LimitW-1:0] LimitReset = 21'd1048576;

  // Name matcher progress: full match length and the sticky miss code.
  localparam logic [4:0] ClNameLen = 5'd14;
  localparam logic [4:0] NameMiss  = 5'd31;

  // Largest accumulator that still takes one more digit without passing 2^31-1.
  localparam logic [LenW-1:0] AccLimLow  = 31'd214748364;  // digits 0..7
  localparam logic [LenW-1:0] AccLimHigh = 31'd214748363;  // digits 8 and 9

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSp    = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

  localparam logic [111:0] ClNameText = "content-length";
  localparam logic [39:0]  ProtoText  = "HTTP/";
  localparam logic [3:0]   ProtoLen   = 4'd5;

  typedef enum logic [2:0] {
    EvNone, EvMethod, EvPathEnd, EvVersion, EvNameEnd, EvValueEnd, EvHeadDone, EvError
  } event_e;

  typedef enum logic [2:0] {
    ErrNone, ErrMethod, ErrPath, ErrVersion, ErrHeader, ErrTooLong
  } error_e;

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lower;
    logic [3:0] digit;
    logic       is_dec;
    logic       is_sp;
    logic       is_cr;
    logic       is_lf;
    logic       is_colon;
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t cls;
    logic      start;
  } item_t;

  // Method text, left aligned in eight bytes.
  function automatic logic [63:0] method_text(input logic [3:0] m);
    logic [63:0] txt;
    case (m)
      4'd0:    txt = {"GET", 40'd0};
      4'd1:    txt = {"HEAD", 32'd0};
      4'd2:    txt = {"OPTIONS", 8'd0};
      4'd3:    txt = {"TRACE", 24'd0};
      4'd4:    txt = {"PUT", 40'd0};
      4'd5:    txt = {"DELETE", 16'd0};
      4'd6:    txt = {"POST", 32'd0};
      4'd7:    txt = {"PATCH", 24'd0};
      4'd8:    txt = "CONNECT" << 8;
      default: txt = '0;
    endcase
    return txt;
  endfunction

  function automatic logic [3:0] method_len(input logic [3:0] m);
    logic [3:0] len;
    case (m)
      4'd0:    len = 4'd3;
      4'd1:    len = 4'd4;
      4'd2:    len = 4'd7;
      4'd3:    len = 4'd5;
      4'd4:    len = 4'd3;
      4'd5:    len = 4'd6;
      4'd6:    len = 4'd4;
      4'd7:    len = 4'd5;
      4'd8:    len = 4'd7;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] method_char(input logic [3:0] m, input logic [2:0] k);
    logic [63:0] txt;
    txt = method_text(m);
    return txt[63 - 8 * int'(k) -: 8];
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] ch;
    if (idx < 4'd14) begin
      ch = ClNameText[111 - 8 * int'(idx) -: 8];
    end else begin
      ch = 8'd0;
    end
    return ch;
  endfunction

  function automatic logic [7:0] proto_char(input logic [2:0] idx);
    logic [7:0] ch;
    if (idx < 3'd5) begin
      ch = ProtoText[39 - 8 * int'(idx) -: 8];
    end else begin
      ch = 8'd0;
    end
    return ch;
  endfunction

endpackage

// File: rtl/hrhp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request bytes and parse results.
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] head_byte;
  logic       start_of_head;

  modport source (output valid, output head_byte, output start_of_head, input ready);
  modport sink (input valid, input head_byte, input start_of_head, output ready);
endinterface

interface hrhp_out_if #(
  parameter int unsigned OFFSET_BITS = hrhp_pkg::OffsetBits,
  parameter int unsigned HDR_BITS    = 9
);
  logic                   valid;
  logic                   ready;
  logic [2:0]             event_res;
  logic [3:0]             method_code;
  logic                   minor_version;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [OFFSET_BITS-1:0] token_length;
  logic [HDR_BITS-1:0]    header_number;
  logic [30:0]            content_length;
  logic                   length_valid;
  logic [2:0]             error_kind;

  modport source (
    output valid, output event_res, output method_code, output minor_version,
    output byte_offset, output token_length, output header_number,
    output content_length, output length_valid, output error_kind, input ready
  );
  modport sink (
    input valid, input event_res, input method_code, input minor_version,
    input byte_offset, input token_length, input header_number,
    input content_length, input length_valid, input error_kind, output ready
  );
endinterface

// File: rtl/hrhp_front.sv
`timescale 1ns / 1ps
// Front end: accept request bytes and classify them for the parser.
module hrhp_front (
  hrhp_in_if.sink         req_i,
  input  logic            full_i,
  output logic            push_o,
  output hrhp_pkg::item_t item_o
);
  import hrhp_pkg::*;

  logic [7:0] b;

  assign b             = req_i.head_byte;
  assign req_i.ready   = !full_i;
  assign push_o        = req_i.valid && !full_i;

  always_comb begin
    item_o.start        = req_i.start_of_head;
    item_o.cls.raw      = b;
    item_o.cls.lower    = (b >= ChUpA && b <= ChUpZ) ? b + 8'd32 : b;
    item_o.cls.digit    = 4'(b - ChZero);
    item_o.cls.is_dec   = (b >= ChZero) && (b <= ChNine);
    item_o.cls.is_sp    = (b == ChSp);
    item_o.cls.is_cr    = (b == ChCr);
    item_o.cls.is_lf    = (b == ChLf);
    item_o.cls.is_colon = (b == ChColon);
  end

endmodule

// File: rtl/hrhp_queue.sv
`timescale 1ns / 1ps
// Short FIFO between the classifier and the parser.
module hrhp_queue #(
  parameter int unsigned DEPTH = hrhp_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hrhp_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output hrhp_pkg::item_t item_o
);
  import hrhp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/hrhp_back.sv
`timescale 1ns / 1ps
// Back end: request head parser state machine with registered result stage.
module hrhp_back #(
  parameter int unsigned MAX_HEADER_COUNT = hrhp_pkg::MaxHeaderCount,
  parameter int unsigned OFFSET_BITS      = hrhp_pkg::OffsetBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hrhp_pkg::LimitW-1:0]   cfg_wdata_i,
  input  logic                          q_valid_i,
  input  hrhp_pkg::item_t               q_item_i,
  output logic                          q_pop_o,
  hrhp_out_if.source                    res_o
);
  import hrhp_pkg::*;

  localparam int unsigned HdrW = $clog2(MAX_HEADER_COUNT + 1);
  localparam int unsigned PosW = OFFSET_BITS + 1;
  localparam int unsigned CmpW = (PosW > LimitW) ? PosW : LimitW;
  localparam logic [HdrW-1:0] HdrMax = HdrW'(MAX_HEADER_COUNT);
  localparam logic [OFFSET_BITS-1:0] OffMax = '1;

  typedef enum logic [3:0] {
    PhIdle, PhMethod, PhMethodSp, PhPath, PhProto, PhVMaj, PhVDot, PhVMin, PhVCr,
    PhReqLf, PhLine, PhLineCr, PhName, PhValue, PhValueLf
  } phase_e;

  typedef enum logic [2:0] {
    LsNone, LsSpaces, LsDigits, LsGood, LsBad
  } lstat_e;

  // Parser state
  phase_e                 phase_q, phase_d, phase_c;
  logic [NumMethods-1:0]  cand_q, cand_d, cand_c;
  logic [3:0]             tok_q, tok_d, tok_c;
  logic [PosW-1:0]        pos_q, pos_d, pos_c;
  logic [PosW-1:0]        ts_q, ts_d, ts_c;
  logic [HdrW-1:0]        hc_q, hc_d, hc_c;
  logic [4:0]             nmp_q, nmp_d, nmp_c;
  logic [LenW-1:0]        acc_q, acc_d, acc_c;
  lstat_e                 ls_q, ls_d, ls_c;
  logic                   minor_q, minor_d, minor_c;
  logic [3:0]             meth_q, meth_d, meth_c;
  logic [LimitW-1:0]      limit_q;

  // Result stage
  logic                   out_valid_q;
  event_e                 ev_q, ev;
  error_e                 err_q, err;
  logic [OFFSET_BITS-1:0] off_q, off;
  logic [OFFSET_BITS-1:0] tlen_q, tlen;
  logic [LenW-1:0]        clen_q, clen;
  logic                   lvalid_q, lvalid;
  logic [3:0]             meth_out_q;
  logic                   minor_out_q;
  logic [HdrW-1:0]        hc_out_q;

  // Byte work
  logic                   take;
  byte_cls_t              cls;
  logic [PosW-1:0]        p;
  logic [NumMethods-1:0]  keep;
  logic                   done_found;
  logic [3:0]             done_code;
  logic [PosW-1:0]        ts_n;
  logic [4:0]             nmp_n;
  logic                   go_name;
  logic [LenW-1:0]        acc_thr;
  logic [LenW+2:0]        acc_x10;

  assign take    = q_valid_i && (!out_valid_q || res_o.ready);
  assign q_pop_o = take;
  assign cls     = q_item_i.cls;
  assign acc_thr = (cls.digit >= 4'd8) ? AccLimHigh : AccLimLow;
  assign acc_x10 = {acc_c, 3'b000} + {2'b00, acc_c, 1'b0};

  always_comb begin
    // A start byte clears the head before the byte is parsed.
    if (q_item_i.start) begin
      phase_c = PhMethod;
      cand_c  = '1;
      tok_c   = '0;
      pos_c   = '0;
      ts_c    = '0;
      hc_c    = '0;
      nmp_c   = '0;
      acc_c   = '0;
      ls_c    = LsNone;
      minor_c = 1'b0;
      meth_c  = '0;
    end else begin
      phase_c = phase_q;
      cand_c  = cand_q;
      tok_c   = tok_q;
      pos_c   = pos_q;
      ts_c    = ts_q;
      hc_c    = hc_q;
      nmp_c   = nmp_q;
      acc_c   = acc_q;
      ls_c    = ls_q;
      minor_c = minor_q;
      meth_c  = meth_q;
    end

    phase_d = phase_c;
    cand_d  = cand_c;
    tok_d   = tok_c;
    pos_d   = pos_c;
    ts_d    = ts_c;
    hc_d    = hc_c;
    nmp_d   = nmp_c;
    acc_d   = acc_c;
    ls_d    = ls_c;
    minor_d = minor_c;
    meth_d  = meth_c;

    ev         = EvNone;
    err        = ErrNone;
    off        = '0;
    tlen       = '0;
    clen       = '0;
    lvalid     = 1'b0;
    p          = pos_c;
    keep       = '0;
    done_found = 1'b0;
    done_code  = '0;
    ts_n       = ts_c;
    nmp_n      = nmp_c;
    go_name    = 1'b0;

    if (phase_c != PhIdle) begin
      off = p[OFFSET_BITS] ? OffMax : p[OFFSET_BITS-1:0];
      if ((CmpW'(p) >= CmpW'(limit_q)) || p[OFFSET_BITS]) begin
        err = ErrTooLong;
      end else begin
        case (phase_c)
          PhMethod: begin
            for (int c = 0; c < NumMethods; c++) begin
              if (cand_c[c] && (tok_c < method_len(4'(c))) &&
                  (method_char(4'(c), tok_c[2:0]) == cls.raw)) begin
                keep[c] = 1'b1;
                if ((tok_c + 4'd1 == method_len(4'(c))) && !done_found) begin
                  done_found = 1'b1;
                  done_code  = 4'(c);
                end
              end
            end
            cand_d = keep;
            tok_d  = tok_c + 4'd1;
            if (keep == '0) begin
              err = ErrMethod;
            end else if (done_found) begin
              meth_d  = done_code;
              ev      = EvMethod;
              phase_d = PhMethodSp;
            end
          end
          PhMethodSp: begin
            if (cls.is_sp) begin
              ts_d    = p + 1'b1;
              phase_d = PhPath;
            end else begin
              err = ErrPath;
            end
          end
          PhPath: begin
            if (cls.is_sp) begin
              ev      = EvPathEnd;
              tlen    = OFFSET_BITS'(p - ts_c);
              tok_d   = '0;
              phase_d = PhProto;
            end
          end
          PhProto: begin
            if ((tok_c < ProtoLen) && (cls.raw == proto_char(tok_c[2:0]))) begin
              tok_d = tok_c + 4'd1;
              if (tok_c + 4'd1 == ProtoLen) begin
                phase_d = PhVMaj;
              end
            end else begin
              err = ErrVersion;
            end
          end
          PhVMaj: begin
            if (cls.raw == ChOne) begin
              phase_d = PhVDot;
            end else begin
              err = ErrVersion;
            end
          end
          PhVDot: begin
            if (cls.raw == ChDot) begin
              phase_d = PhVMin;
            end else if (cls.is_cr) begin
              minor_d = 1'b0;
              phase_d = PhReqLf;
            end else begin
              err = ErrVersion;
            end
          end
          PhVMin: begin
            if (cls.raw == ChZero || cls.raw == ChOne) begin
              minor_d = cls.digit[0];
              phase_d = PhVCr;
            end else begin
              err = ErrVersion;
            end
          end
          PhVCr: begin
            if (cls.is_cr) begin
              phase_d = PhReqLf;
            end else begin
              err = ErrVersion;
            end
          end
          PhReqLf: begin
            if (cls.is_lf) begin
              ev      = EvVersion;
              phase_d = PhLine;
            end else begin
              err = ErrVersion;
            end
          end
          PhLine, PhLineCr, PhName: begin
            go_name = 1'b1;
            if (phase_c == PhLine) begin
              ts_n  = p;
              nmp_n = '0;
              if (cls.is_cr) begin
                phase_d = PhLineCr;
                go_name = 1'b0;
              end
            end else if (phase_c == PhLineCr) begin
              if (cls.is_lf) begin
                ev      = EvHeadDone;
                phase_d = PhIdle;
                go_name = 1'b0;
                if (ls_c == LsGood) begin
                  lvalid = 1'b1;
                  clen   = acc_c;
                end
              end else begin
                // Lone CR opens a name that can no longer match.
                nmp_n = NameMiss;
              end
            end
            ts_d  = ts_n;
            nmp_d = nmp_n;
            if (go_name) begin
              phase_d = PhName;
              if (cls.is_colon) begin
                ev   = EvNameEnd;
                tlen = OFFSET_BITS'(p - ts_n);
                if ((nmp_n == ClNameLen) && (ls_c == LsNone) && (hc_c < HdrMax)) begin
                  ls_d  = LsSpaces;
                  acc_d = '0;
                end
                ts_d    = p + 1'b1;
                phase_d = PhValue;
              end else if ((nmp_n < ClNameLen) && (cls.lower == cl_char(nmp_n[3:0]))) begin
                nmp_d = nmp_n + 5'd1;
              end else begin
                nmp_d = NameMiss;
              end
            end
          end
          PhValue: begin
            if (cls.is_cr) begin
              ev   = EvValueEnd;
              tlen = OFFSET_BITS'(p - ts_c);
              if (ls_c == LsSpaces) begin
                ls_d = LsBad;
              end else if (ls_c == LsDigits) begin
                ls_d = LsGood;
              end
              phase_d = PhValueLf;
            end else if (ls_c == LsSpaces) begin
              if (!cls.is_sp) begin
                if (cls.is_dec) begin
                  acc_d = LenW'(cls.digit);
                  ls_d  = LsDigits;
                end else begin
                  ls_d = LsBad;
                end
              end
            end else if (ls_c == LsDigits) begin
              if (!cls.is_dec || (acc_c > acc_thr)) begin
                ls_d = LsBad;
              end else begin
                acc_d = LenW'(acc_x10 + (LenW + 3)'(cls.digit));
              end
            end
          end
          PhValueLf: begin
            if (cls.is_lf) begin
              if (hc_c < HdrMax) begin
                hc_d = hc_c + 1'b1;
              end
              phase_d = PhLine;
            end else begin
              err = ErrHeader;
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
      if (err != ErrNone) begin
        ev      = EvError;
        tlen    = '0;
        phase_d = PhIdle;
      end
      pos_d = p + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      cand_q      <= '0;
      tok_q       <= '0;
      pos_q       <= '0;
      ts_q        <= '0;
      hc_q        <= '0;
      nmp_q       <= '0;
      acc_q       <= '0;
      ls_q        <= LsNone;
      minor_q     <= 1'b0;
      meth_q      <= '0;
      limit_q     <= LimitReset;
      out_valid_q <= 1'b0;
      ev_q        <= EvNone;
      err_q       <= ErrNone;
      off_q       <= '0;
      tlen_q      <= '0;
      clen_q      <= '0;
      lvalid_q    <= 1'b0;
      meth_out_q  <= '0;
      minor_out_q <= 1'b0;
      hc_out_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (take) begin
        phase_q     <= phase_d;
        cand_q      <= cand_d;
        tok_q       <= tok_d;
        pos_q       <= pos_d;
        ts_q        <= ts_d;
        hc_q        <= hc_d;
        nmp_q       <= nmp_d;
        acc_q       <= acc_d;
        ls_q        <= ls_d;
        minor_q     <= minor_d;
        meth_q      <= meth_d;
        out_valid_q <= 1'b1;
        ev_q        <= ev;
        err_q       <= err;
        off_q       <= off;
        tlen_q      <= tlen;
        clen_q      <= clen;
        lvalid_q    <= lvalid;
        meth_out_q  <= meth_d;
        minor_out_q <= minor_d;
        hc_out_q    <= hc_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.event_res      = ev_q;
  assign res_o.method_code    = meth_out_q;
  assign res_o.minor_version  = minor_out_q;
  assign res_o.byte_offset    = off_q;
  assign res_o.token_length   = tlen_q;
  assign res_o.header_number  = hc_out_q;
  assign res_o.content_length = clen_q;
  assign res_o.length_valid   = lvalid_q;
  assign res_o.error_kind     = err_q;

endmodule

// File: rtl/http_request_head_parser_top.sv
`timescale 1ns / 1ps
// A byte accepted on req_i is written into the queue, then parsed into the registered result stage.
// Throughput: one byte per cycle, sustained while res_o takes every result; the parser updates its state per byte.
// A two-entry queue sits between classifier and parser, so res_o back-pressure stalls req_i
// once the queue has filled, and req_i stays low until the registered queue count drops after res_o takes again.
// Reset (rst_ni low, async): parser idle, queue and result register empty, head_limit 1048576.
// No clearing pass: the block takes bytes from the first cycle after reset.
module http_request_head_parser_top #(
  parameter int unsigned MAX_HEADER_COUNT = hrhp_pkg::MaxHeaderCount,
  parameter int unsigned OFFSET_BITS      = hrhp_pkg::OffsetBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [hrhp_pkg::LimitW-1:0] cfg_wdata_i,
  hrhp_in_if.sink                     req_i,
  hrhp_out_if.source                  res_o
);
  import hrhp_pkg::*;

  // Classifier to queue
  logic  push;
  logic  full;
  item_t push_item;

  // Queue to parser
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Classify each byte as it arrives: case fold, digit value and delimiter flags.
  hrhp_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  // Decouple the byte stream from the parser so a stalled result does not
  // immediately stall the link side.
  hrhp_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Parse one byte per cycle whenever the result register can take a result;
  // also holds the head_limit register written through the config port.
  hrhp_back #(
    .MAX_HEADER_COUNT (MAX_HEADER_COUNT),
    .OFFSET_BITS      (OFFSET_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .res_o       (res_o)
  );

endmodule
